FILE: rtl/mesh_route_table_engine_macros.svh
// Assertion macros for the mesh route table engine.
// Taken in by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MESH_ROUTE_TABLE_ENGINE_MACROS_SVH
`define MESH_ROUTE_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrte check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrte check failed");

`endif

FILE: rtl/mrte_pkg.sv
// Shared types and constants for the mesh route table engine.
// No dependencies.
package mrte_pkg;

    localparam int NODE_W   = 32;
    localparam int SEQ_W    = 32;
    localparam int HOPS_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_REPLACED = 3'd3,
        ST_KEPT     = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [SEQ_W-1:0]  seq;
        logic [HOPS_W-1:0] hops;
        logic [NODE_W-1:0] via;
    } t_entry;

endpackage

FILE: rtl/mrte_req_if.sv
// Request channel of the mesh route table engine: valid/ready plus one item.
// Depends on mrte_pkg for field widths.
interface mrte_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [mrte_pkg::NODE_W-1:0] target_node;
    logic [mrte_pkg::SEQ_W-1:0]  target_seq;
    logic [mrte_pkg::HOPS_W-1:0] hops;
    logic [mrte_pkg::NODE_W-1:0] via_node;

    modport source (output valid, op, target_node, target_seq, hops, via_node, input ready);
    modport sink   (input valid, op, target_node, target_seq, hops, via_node, output ready);
endinterface

FILE: rtl/mrte_rsp_if.sv
// Response channel of the mesh route table engine: valid/ready plus one item.
// Depends on mrte_pkg for field widths.
interface mrte_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mrte_pkg::STATUS_W-1:0] status;
    logic [mrte_pkg::SLOT_W-1:0]   slot;
    logic [mrte_pkg::NODE_W-1:0]   route_via;
    logic [mrte_pkg::HOPS_W-1:0]   route_hops;
    logic [mrte_pkg::SEQ_W-1:0]    route_seq;

    modport source (output valid, status, slot, route_via, route_hops, route_seq, input ready);
    modport sink   (input valid, status, slot, route_via, route_hops, route_seq, output ready);
endinterface

FILE: rtl/mrte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrte_ram #(
    parameter int WIDTH = 104,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mesh_route_table_engine.sv
// Mesh route table engine top level: sequencer, one slot comparator, entry RAM.
// Depends on mrte_pkg, mrte_req_if, mrte_rsp_if, mrte_ram and the macros header.
//
//   channel  dir  handshake      item
//   i_req    in   valid/ready    op, target_node, target_seq, hops, via_node
//   o_rsp    out  valid/ready    status, slot, route_via, route_hops, route_seq
//
// Each item scans the filled slots in order: one RAM read per filled slot through
// the single node comparator, plus the last compare.
// Scan stops early at the first matching slot.
// One item at a time; i_req.ready is high only while idle, result held until taken.
// Next item accepted only once the result is taken and the sequencer is back in idle.
// Synchronous active-low reset empties the table; entry RAM needs no clearing.
`include "mesh_route_table_engine_macros.svh"

module mesh_route_table_engine #(
    parameter int ROUTE_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrte_req_if.sink   i_req,
    mrte_rsp_if.source o_rsp
);

    localparam int IW = $clog2(ROUTE_SLOTS);
    localparam int CW = $clog2(ROUTE_SLOTS + 1);
    localparam int EW = $bits(mrte_pkg::t_entry);

    mrte_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_used, n_used;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_rd_pend, n_rd_pend;
    logic [IW-1:0]    r_cmp_idx, n_cmp_idx;

    logic             r_op, n_op;
    mrte_pkg::t_entry r_new, n_new;

    mrte_pkg::t_status           r_status, n_status;
    logic [mrte_pkg::SLOT_W-1:0] r_slot, n_slot;
    mrte_pkg::t_entry            r_rsp, n_rsp;

    logic             ram_we, ram_re, hit, ins;
    logic [IW-1:0]    ram_waddr;
    mrte_pkg::t_entry ram_wdata, ram_rdata;

    mrte_ram #(
        .WIDTH (EW),
        .DEPTH (ROUTE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrte_pkg::S_IDLE;
            r_used    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_rd_pend <= n_rd_pend;
        end
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_op      <= n_op;
        r_new     <= n_new;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_rsp     <= n_rsp;
    end

    assign hit = r_rd_pend && (ram_rdata.node == r_new.node);

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_rd_idx  = r_rd_idx;
        n_rd_pend = r_rd_pend;
        n_cmp_idx = r_cmp_idx;
        n_op      = r_op;
        n_new     = r_new;
        n_status  = r_status;
        n_slot    = r_slot;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_cmp_idx;
        ram_wdata = r_new;
        ins       = 1'b0;

        unique case (r_state)
            mrte_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state   = mrte_pkg::S_SCAN;
                    n_op      = i_req.op;
                    n_new     = '{node: i_req.target_node, seq: i_req.target_seq,
                                  hops: i_req.hops, via: i_req.via_node};
                    n_rd_idx  = '0;
                    n_rd_pend = 1'b0;
                end
            end
            mrte_pkg::S_SCAN: begin
                n_rd_pend = 1'b0;
                if (hit) begin
                    n_state = mrte_pkg::S_OUT;
                    n_slot  = mrte_pkg::SLOT_W'(r_cmp_idx);
                    if (r_op == mrte_pkg::OP_LOOKUP) begin
                        n_status = mrte_pkg::ST_HIT;
                        n_rsp    = ram_rdata;
                    end else if (ram_rdata.hops > r_new.hops) begin
                        ram_we   = 1'b1;
                        n_status = mrte_pkg::ST_REPLACED;
                        n_rsp    = r_new;
                    end else begin
                        n_status = mrte_pkg::ST_KEPT;
                        n_rsp    = ram_rdata;
                    end
                end else if (r_rd_idx < r_used) begin
                    ram_re    = 1'b1;
                    n_rd_pend = 1'b1;
                    n_cmp_idx = r_rd_idx[IW-1:0];
                    n_rd_idx  = CW'(r_rd_idx + 1'b1);
                end else begin
                    n_state = mrte_pkg::S_OUT;
                    n_slot  = '0;
                    n_rsp   = '0;
                    if (r_op == mrte_pkg::OP_LOOKUP) begin
                        n_status = mrte_pkg::ST_MISS;
                    end else if (r_used == CW'(ROUTE_SLOTS)) begin
                        n_status = mrte_pkg::ST_FULL;
                    end else begin
                        ins       = 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = r_used[IW-1:0];
                        n_used    = CW'(r_used + 1'b1);
                        n_status  = mrte_pkg::ST_INSERTED;
                        n_slot    = mrte_pkg::SLOT_W'(r_used);
                        n_rsp     = r_new;
                    end
                end
            end
            mrte_pkg::S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = mrte_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrte_pkg::S_IDLE;
            end
        endcase
    end

    assign i_req.ready      = (r_state == mrte_pkg::S_IDLE);
    assign o_rsp.valid      = (r_state == mrte_pkg::S_OUT);
    assign o_rsp.status     = r_status;
    assign o_rsp.slot       = r_slot;
    assign o_rsp.route_via  = r_rsp.via;
    assign o_rsp.route_hops = r_rsp.hops;
    assign o_rsp.route_seq  = r_rsp.seq;

    `MRTE_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CW'(ROUTE_SLOTS))
    `MRTE_ASSERT_IMPL(a_we_in_scan, i_clk, i_rst_n, ram_we, r_state == mrte_pkg::S_SCAN)
    `MRTE_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, ins, r_used == CW'($past(r_used) + 1'b1))
    `MRTE_ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, i_req.valid && i_req.ready,
                      r_rd_idx == '0 && !r_rd_pend)

endmodule

FILE: verif/mesh_route_table_engine_tb.sv
// Testbench for mesh_route_table_engine: a directed table, then random lookups and updates.
// Results are checked in order against a behavioural route table held in the bench.
// Depends on mrte_pkg, mrte_req_if, mrte_rsp_if and the RTL of the block.
`timescale 1ns / 1ps

module mesh_route_table_engine_tb;

    localparam int ROUTE_SLOTS    = 16;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int MAX_GAP        = 18;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        mrte_pkg::t_status                   status;
        logic [mrte_pkg::SLOT_W-1:0]         slot;
        logic [mrte_pkg::NODE_W-1:0]         via;
        logic [mrte_pkg::HOPS_W-1:0]         hops;
        logic [mrte_pkg::SEQ_W-1:0]          seq;
    } t_route_rsp;

    typedef struct {
        mrte_pkg::t_op                       op;
        logic [mrte_pkg::NODE_W-1:0]         node;
        logic [mrte_pkg::SEQ_W-1:0]          seq;
        logic [mrte_pkg::HOPS_W-1:0]         hops;
        logic [mrte_pkg::NODE_W-1:0]         via;
        bit                                  typed;
        t_route_rsp                          want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    mrte_req_if req_ch ();
    mrte_rsp_if rsp_ch ();

    mesh_route_table_engine #(
        .ROUTE_SLOTS(ROUTE_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mrte_pkg::t_entry route_copy [ROUTE_SLOTS];
    int unsigned      routes_used;
    t_route_rsp       pending_routes [$];
    t_stim_row        directed_rows [$];
    int unsigned      mismatch_count = 0;
    int unsigned      rsp_count = 0;
    int unsigned      idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_route_rsp predict_route(mrte_pkg::t_op op,
                                                 logic [mrte_pkg::NODE_W-1:0] node,
                                                 logic [mrte_pkg::SEQ_W-1:0] seq,
                                                 logic [mrte_pkg::HOPS_W-1:0] hops,
                                                 logic [mrte_pkg::NODE_W-1:0] via);
        t_route_rsp r;
        int         found;
        found = -1;
        for (int i = 0; i < routes_used; i++) begin
            if (found < 0 && route_copy[i].node == node)
                found = i;
        end
        r = '{mrte_pkg::ST_MISS, '0, '0, '0, '0};
        if (op == mrte_pkg::OP_LOOKUP) begin
            if (found >= 0)
                r.status = mrte_pkg::ST_HIT;
        end else if (found < 0) begin
            if (routes_used >= ROUTE_SLOTS) begin
                r.status = mrte_pkg::ST_FULL;
            end else begin
                found = int'(routes_used);
                route_copy[found] = '{node, seq, hops, via};
                routes_used++;
                r.status = mrte_pkg::ST_INSERTED;
            end
        end else if (route_copy[found].hops > hops) begin
            route_copy[found].seq  = seq;
            route_copy[found].hops = hops;
            route_copy[found].via  = via;
            r.status = mrte_pkg::ST_REPLACED;
        end else begin
            r.status = mrte_pkg::ST_KEPT;
        end
        if (found >= 0) begin
            r.slot = mrte_pkg::SLOT_W'(found);
            r.via  = route_copy[found].via;
            r.hops = route_copy[found].hops;
            r.seq  = route_copy[found].seq;
        end
        return r;
    endfunction

    function automatic void add_row(mrte_pkg::t_op op, logic [mrte_pkg::NODE_W-1:0] node,
                                    logic [mrte_pkg::SEQ_W-1:0] seq,
                                    logic [mrte_pkg::HOPS_W-1:0] hops,
                                    logic [mrte_pkg::NODE_W-1:0] via,
                                    bit typed, t_route_rsp want);
        t_stim_row row;
        row = '{op, node, seq, hops, via, typed, want};
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t: result %0d %s: got %h, want %h", $realtime, rsp_count, what, got, want);
    endtask

    task automatic send_route_item(mrte_pkg::t_op op, logic [mrte_pkg::NODE_W-1:0] node,
                                   logic [mrte_pkg::SEQ_W-1:0] seq,
                                   logic [mrte_pkg::HOPS_W-1:0] hops,
                                   logic [mrte_pkg::NODE_W-1:0] via,
                                   int unsigned gap, bit typed, t_route_rsp want);
        t_route_rsp predicted;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.target_node <= node;
        req_ch.target_seq  <= seq;
        req_ch.hops        <= hops;
        req_ch.via_node    <= via;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = predict_route(op, node, seq, hops, via);
        pending_routes.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_routes.size() != 0);
    endtask

    // result side
    initial begin
        int unsigned stall;
        t_route_rsp  want;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = ((rsp_count % 350) >= 250) ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            if (pending_routes.size() == 0) begin
                report_mismatch("unexpected, status", 32'(rsp_ch.status), '0);
            end else begin
                want = pending_routes.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.slot !== want.slot)
                    report_mismatch("slot", 32'(rsp_ch.slot), 32'(want.slot));
                if (rsp_ch.route_via !== want.via)
                    report_mismatch("route_via", rsp_ch.route_via, want.via);
                if (rsp_ch.route_hops !== want.hops)
                    report_mismatch("route_hops", 32'(rsp_ch.route_hops), 32'(want.hops));
                if (rsp_ch.route_seq !== want.seq)
                    report_mismatch("route_seq", rsp_ch.route_seq, want.seq);
            end
            rsp_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mesh_route_table_engine_tb failed");
            $finish;
        end
    end

    // request side
    initial begin
        t_route_rsp                  none;
        mrte_pkg::t_op               op;
        logic [mrte_pkg::NODE_W-1:0] node;
        logic [mrte_pkg::HOPS_W-1:0] hops;
        int unsigned                 pick;
        int unsigned                 gap;

        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= mrte_pkg::OP_LOOKUP;
        req_ch.target_node <= '0;
        req_ch.target_seq  <= '0;
        req_ch.hops        <= '0;
        req_ch.via_node    <= '0;
        routes_used    = 0;
        none = '{mrte_pkg::ST_MISS, '0, '0, '0, '0};

        // empty table, extremes, kept and replaced, then fill to full and probe the full table
        add_row(mrte_pkg::OP_LOOKUP, '0, $urandom, 8'($urandom), $urandom, 1, none);
        add_row(mrte_pkg::OP_UPDATE, '1, '1, '1, '1, 1,
                '{mrte_pkg::ST_INSERTED, 4'd0, '1, '1, '1});
        add_row(mrte_pkg::OP_LOOKUP, '1, $urandom, 8'($urandom), $urandom, 1,
                '{mrte_pkg::ST_HIT, 4'd0, '1, '1, '1});
        add_row(mrte_pkg::OP_UPDATE, '1, '0, '1, '0, 1,
                '{mrte_pkg::ST_KEPT, 4'd0, '1, '1, '1});
        add_row(mrte_pkg::OP_UPDATE, '1, 32'h5a5a_5a5a, 8'hfe, 32'ha5a5_a5a5, 1,
                '{mrte_pkg::ST_REPLACED, 4'd0, 32'ha5a5_a5a5, 8'hfe, 32'h5a5a_5a5a});
        add_row(mrte_pkg::OP_UPDATE, '0, '0, '0, '0, 1,
                '{mrte_pkg::ST_INSERTED, 4'd1, '0, '0, '0});
        add_row(mrte_pkg::OP_UPDATE, '0, '1, '0, '1, 1,
                '{mrte_pkg::ST_KEPT, 4'd1, '0, '0, '0});
        add_row(mrte_pkg::OP_LOOKUP, '0, $urandom, 8'($urandom), $urandom, 1,
                '{mrte_pkg::ST_HIT, 4'd1, '0, '0, '0});
        add_row(mrte_pkg::OP_LOOKUP, 32'h8000_0000, $urandom, 8'($urandom), $urandom, 1,
                none);
        for (int k = 2; k < ROUTE_SLOTS; k++)
            add_row(mrte_pkg::OP_UPDATE, {16'($urandom), 8'hc3, 8'(k)}, $urandom,
                    8'($urandom), $urandom, 0, none);
        add_row(mrte_pkg::OP_UPDATE, 32'h0000_0001, $urandom, 8'($urandom), $urandom, 1,
                '{mrte_pkg::ST_FULL, 4'd0, '0, '0, '0});
        add_row(mrte_pkg::OP_LOOKUP, 32'h0000_0001, $urandom, 8'($urandom), $urandom, 1,
                none);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_route_item(directed_rows[k].op, directed_rows[k].node, directed_rows[k].seq,
                            directed_rows[k].hops, directed_rows[k].via,
                            $urandom_range(0, MAX_GAP), directed_rows[k].typed,
                            directed_rows[k].want);
        wait_for_results();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2)
                wait_for_results();
            op   = mrte_pkg::t_op'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 60)
                node = route_copy[$urandom_range(0, routes_used - 1)].node;
            else if (pick < 75)
                node = route_copy[$urandom_range(0, routes_used - 1)].node
                       ^ (32'd1 << $urandom_range(0, 31));
            else
                node = $urandom;
            hops = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15));
            gap  = ((k % 400) >= 300) ? 0 : $urandom_range(0, MAX_GAP);
            send_route_item(op, node, $urandom, hops, $urandom, gap, 0, none);
        end

        req_ch.valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("mesh_route_table_engine_tb passed");
        else
            $display("mesh_route_table_engine_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mrte_pkg.sv
rtl/mrte_req_if.sv
rtl/mrte_rsp_if.sv
rtl/mrte_ram.sv
rtl/mesh_route_table_engine.sv
verif/mesh_route_table_engine_tb.sv
